[sv/xmt_pkg.sv]
`default_nettype none
package xmt_pkg;

	localparam int unsigned VALUE_BITS_DEF = 16;
	localparam int unsigned COUNT_BITS_DEF = 16;

	localparam logic [1:0] FN_INS = 2'd0;
	localparam logic [1:0] FN_REM = 2'd1;
	localparam logic [1:0] FN_QRY = 2'd2;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_ABSENT = 2'd1;
	localparam logic [1:0] ST_SAT    = 2'd2;

endpackage
`default_nettype wire

[sv/xmt_mem.sv]
`default_nettype none
module xmt_mem #(
	parameter int unsigned AW    = xmt_pkg::VALUE_BITS_DEF,
	parameter int unsigned WIDTH = xmt_pkg::COUNT_BITS_DEF,
	parameter bit          SHORT = 1'b0
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);
	localparam longint unsigned DEPTH = (64'd1 << AW) - 64'(SHORT);

	logic [WIDTH-1:0] mem [0:DEPTH-1];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

[sv/xor_mex_multiset_trie_core.sv]
// insert and remove: FETCH then DONE when no trie count changes,
// FETCH, PATH, DONE when the first or last copy of a value changes the path counts
// query: FETCH, QWALK one trie level per cycle, DONE; only FETCH, DONE on a full set
// m_tvalid rises together with s_tready, as the request leaves DONE
// a result held by m_tready low stalls the next request in DONE
// after reset a clearing pass over every address zeroes both memories, s_tready low
`default_nettype none
module xor_mex_multiset_trie_core #(
	parameter int unsigned VALUE_BITS = xmt_pkg::VALUE_BITS_DEF,
	parameter int unsigned COUNT_BITS = xmt_pkg::COUNT_BITS_DEF
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   s_tvalid,
	output logic                                        s_tready,
	input  wire logic [((VALUE_BITS+7)/8)*8-1:0]        s_tdata,  // operand
	input  wire logic [1:0]                             s_tuser,  // func
	output logic                                        m_tvalid,
	input  wire logic                                   m_tready,
	output logic      [((VALUE_BITS+3+7)/8)*8-1:0]      m_tdata   // mex, status
);
	import xmt_pkg::*;

	localparam int unsigned VB    = VALUE_BITS;
	localparam int unsigned OUT_W = ((VALUE_BITS+3+7)/8)*8;

	localparam logic [2:0] S_CLR   = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_FETCH = 3'd2;
	localparam logic [2:0] S_PATH  = 3'd3;
	localparam logic [2:0] S_QWALK = 3'd4;
	localparam logic [2:0] S_DONE  = 3'd5;

	logic [2:0]            state_q;
	logic [VB-1:0]         clr_q;
	logic [1:0]            func_q;
	logic [VB-1:0]         val_q;
	logic [VB-1:0]         addr_q;
	logic [VB:0]           cur_q;
	logic [VB-1:0]         cap_q;
	logic [VB:0]           mex_q;
	logic [1:0]            st_q;
	logic                  dec_q;
	logic                  out_valid_q;
	logic [VB:0]           out_mex_q;
	logic [1:0]            out_st_q;

	logic                  mult_we;
	logic [VB-1:0]         mult_waddr;
	logic [COUNT_BITS-1:0] mult_wdata;
	logic [VB-1:0]         mult_raddr;
	logic [COUNT_BITS-1:0] mult_rd;
	logic                  sd_we;
	logic [VB-1:0]         sd_waddr;
	logic [VB:0]           sd_wdata;
	logic [VB-1:0]         sd_raddr;
	logic [VB:0]           sd_rd;

	logic                  full;
	logic [VB:0]           node;
	logic [VB:0]           next_c;
	logic                  accept;
	logic                  out_free;

	assign accept   = s_tvalid && s_tready;
	assign s_tready = (state_q == S_IDLE);
	assign out_free = !out_valid_q || m_tready;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_W'({out_st_q, out_mex_q});

	assign full = cap_q[0] ? (|mult_rd) : (sd_rd == {1'b0, cap_q});

	always_comb begin
		case (state_q)
			S_PATH:  node = cur_q;
			S_QWALK: node = {cur_q[VB:1], cur_q[0] ^ full};
			default: node = (VB+1)'(1);
		endcase
		next_c = {node[VB-1:0], val_q[VB-1]};
	end

	always_comb begin
		mult_raddr = next_c[VB-1:0];
		sd_raddr   = next_c[VB-1:0] - VB'(1);
		if (state_q == S_IDLE) begin
			mult_raddr = s_tdata[VB-1:0];
			sd_raddr   = '0;
		end else if (state_q == S_FETCH && func_q != FN_QRY) begin
			sd_raddr = '0;
		end
	end

	always_comb begin
		mult_we    = 1'b0;
		mult_waddr = addr_q;
		mult_wdata = mult_rd;
		sd_we      = 1'b0;
		sd_waddr   = cur_q[VB-1:0] - VB'(1);
		sd_wdata   = dec_q ? (sd_rd - (VB+1)'(1)) : (sd_rd + (VB+1)'(1));
		case (state_q)
			S_CLR: begin
				mult_we    = 1'b1;
				mult_waddr = clr_q;
				mult_wdata = '0;
				sd_we      = !(&clr_q);
				sd_waddr   = clr_q;
				sd_wdata   = '0;
			end
			S_FETCH: begin
				if (func_q == FN_INS && !(&mult_rd)) begin
					mult_we    = 1'b1;
					mult_wdata = mult_rd + COUNT_BITS'(1);
				end else if (func_q == FN_REM && (|mult_rd)) begin
					mult_we    = 1'b1;
					mult_wdata = mult_rd - COUNT_BITS'(1);
				end
			end
			S_PATH: begin
				sd_we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	xmt_mem #(.AW(VB), .WIDTH(COUNT_BITS), .SHORT(1'b0)) u_mult (
		.clk   (clk),
		.we    (mult_we),
		.waddr (mult_waddr),
		.wdata (mult_wdata),
		.raddr (mult_raddr),
		.rdata (mult_rd)
	);

	xmt_mem #(.AW(VB), .WIDTH(VB+1), .SHORT(1'b1)) u_sd (
		.clk   (clk),
		.we    (sd_we),
		.waddr (sd_waddr),
		.wdata (sd_wdata),
		.raddr (sd_raddr),
		.rdata (sd_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLR: begin
					clr_q <= clr_q + VB'(1);
					if (&clr_q) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						state_q <= S_FETCH;
					end
				end
				S_FETCH: begin
					state_q <= S_DONE;
					if (func_q == FN_INS && mult_rd == '0) begin
						state_q <= S_PATH;
					end else if (func_q == FN_REM && mult_rd == COUNT_BITS'(1)) begin
						state_q <= S_PATH;
					end else if (func_q == FN_QRY && !sd_rd[VB]) begin
						state_q <= S_QWALK;
					end
				end
				S_PATH, S_QWALK: begin
					if (cap_q[0]) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				func_q <= s_tuser;
				val_q  <= s_tdata[VB-1:0];
				addr_q <= s_tdata[VB-1:0];
			end
			S_FETCH: begin
				cap_q <= VB'(1) << (VB-1);
				mex_q <= '0;
				st_q  <= ST_OK;
				dec_q <= (func_q == FN_REM);
				cur_q <= (VB+1)'(1);
				if (func_q == FN_INS && (&mult_rd)) begin
					st_q <= ST_SAT;
				end else if (func_q == FN_REM && mult_rd == '0) begin
					st_q <= ST_ABSENT;
				end else if (func_q == FN_QRY) begin
					if (sd_rd[VB]) begin
						mex_q <= (VB+1)'(1) << VB;
					end
					cur_q <= next_c;
					val_q <= val_q << 1;
				end
			end
			S_PATH: begin
				cur_q <= next_c;
				val_q <= val_q << 1;
				cap_q <= cap_q >> 1;
			end
			S_QWALK: begin
				mex_q <= {mex_q[VB-1:0], full};
				cur_q <= next_c;
				val_q <= val_q << 1;
				cap_q <= cap_q >> 1;
			end
			S_DONE: begin
				if (out_free) begin
					out_mex_q <= mex_q;
					out_st_q  <= st_q;
				end
			end
			default: begin
			end
		endcase
	end

`ifndef SYNTH
	a_cap_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PATH || state_q == S_QWALK) |-> $onehot(cap_q))
		else $error("level marker lost its single bit");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_QWALK && !cap_q[0]) |-> (sd_rd <= {1'b0, cap_q}))
		else $error("subtree count exceeds subtree size");

	a_full_mex: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(out_mex_q[VB] && (|out_mex_q[VB-1:0])))
		else $error("full-set answer carries low bits");

	a_query_status: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && func_q == FN_QRY) |-> (st_q == ST_OK))
		else $error("query reports a nonzero status");
`endif

endmodule
`default_nettype wire

[verif/tb.sv]
`timescale 1ns / 1ps
module tb;
	import xmt_pkg::*;

	localparam int VB = VALUE_BITS_DEF;
	localparam int CB = COUNT_BITS_DEF;
	localparam int LEAVES = 1 << VB;
	localparam int DW = ((VB + 7) / 8) * 8;
	localparam int RW = ((VB + 3 + 7) / 8) * 8;
	localparam logic [1:0] FN_NONE = 2'd3;
	localparam bit [CB-1:0] COUNT_MAX = '1;
	localparam logic [VB:0] FULL_MEX = {1'b1, {VB{1'b0}}};
	localparam int RAND_ITEMS = 700;
	localparam int HOLD_CYCLES = 300;
	localparam int WATCHDOG_LIMIT = 300000;

	typedef struct packed {
		logic [1:0]    fn;
		logic [VB-1:0] opnd;
		logic [VB:0]   mex;
		logic [1:0]    st;
	} outcome_t;

	typedef struct {
		logic [1:0]    fn;
		logic [VB-1:0] opnd;
		bit            typed;
		logic [VB:0]   mex;
		logic [1:0]    st;
	} row_t;

	logic          clk;
	logic          arst_n;
	logic          s_tvalid;
	logic          s_tready;
	logic [DW-1:0] s_tdata;
	logic [1:0]    s_tuser;
	logic          m_tvalid;
	logic          m_tready;
	logic [RW-1:0] m_tdata;

	// shadow of the trie: per-value counts and distinct counts per heap node
	bit [CB-1:0] mult_cnt [LEAVES];
	bit [VB:0]   node_cnt [LEAVES];

	outcome_t pending_results [$];
	row_t     dir_rows [$];

	int  errors;
	int  idle_cycles;
	int  rx_gap;
	bit  quiet;
	bit  hold_req;
	int  n_req, n_qry, n_absent, n_sat, n_full, n_none, n_holds;
	int  max_mex;

	xor_mex_multiset_trie_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic void path_add(input logic [VB-1:0] v, input bit up);
		int unsigned vi;
		int unsigned node;
		vi = 32'(v);
		for (int d = 0; d < VB; d++) begin
			node = (1 << d) | (vi >> (VB - d));
			if (up)
				node_cnt[node] = node_cnt[node] + (VB+1)'(1);
			else
				node_cnt[node] = node_cnt[node] - (VB+1)'(1);
		end
	endfunction

	// walk from the root, taking the key branch unless that subtree is full
	function automatic logic [VB:0] xor_mex(input logic [VB-1:0] key);
		int unsigned node;
		int unsigned ch;
		int unsigned lvl;
		bit k;
		bit full;
		logic [VB:0] m;
		if (node_cnt[1] == LEAVES)
			return FULL_MEX;
		node = 1;
		m = '0;
		for (int d = 0; d < VB; d++) begin
			lvl = VB - 1 - d;
			k = key[lvl];
			ch = node * 2 + k;
			if (d + 1 < VB)
				full = (node_cnt[ch] == (1 << lvl));
			else
				full = (mult_cnt[ch - LEAVES] != 0);
			if (full) begin
				m[lvl] = 1'b1;
				ch = node * 2 + (k ^ 1'b1);
			end
			node = ch;
		end
		return m;
	endfunction

	function automatic outcome_t trie_apply(input logic [1:0] fn, input logic [VB-1:0] v);
		outcome_t r;
		r.fn = fn;
		r.opnd = v;
		r.mex = '0;
		r.st = ST_OK;
		case (fn)
			FN_INS: begin
				if (mult_cnt[v] == COUNT_MAX) begin
					r.st = ST_SAT;
				end else begin
					if (mult_cnt[v] == 0)
						path_add(v, 1'b1);
					mult_cnt[v] = mult_cnt[v] + CB'(1);
				end
			end
			FN_REM: begin
				if (mult_cnt[v] == 0) begin
					r.st = ST_ABSENT;
				end else begin
					if (mult_cnt[v] == 1)
						path_add(v, 1'b0);
					mult_cnt[v] = mult_cnt[v] - CB'(1);
				end
			end
			FN_QRY: begin
				r.mex = xor_mex(v);
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	function automatic void dir_row(input logic [1:0] fn, input logic [VB-1:0] opnd,
			input bit typed, input logic [VB:0] mex, input logic [1:0] st);
		row_t r;
		r.fn = fn;
		r.opnd = opnd;
		r.typed = typed;
		r.mex = mex;
		r.st = st;
		dir_rows.push_back(r);
	endfunction

	task automatic issue_request(input logic [1:0] fn, input logic [VB-1:0] opnd,
			input bit typed, input logic [VB:0] exp_mex, input logic [1:0] exp_st);
		int n;
		outcome_t o;
		n = quiet ? 0 : pick_gap();
		if (n > 0) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat (n - 1) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata <= DW'(opnd);
		s_tuser <= fn;
		do @(posedge clk); while (!s_tready);
		o = trie_apply(fn, opnd);
		n_req++;
		if (fn == FN_QRY) begin
			n_qry++;
			if (o.mex == FULL_MEX)
				n_full++;
			else if (int'(o.mex) > max_mex)
				max_mex = int'(o.mex);
		end
		if (fn == FN_NONE)
			n_none++;
		if (o.st == ST_ABSENT)
			n_absent++;
		if (o.st == ST_SAT)
			n_sat++;
		if (typed) begin
			o.mex = exp_mex;
			o.st = exp_st;
		end
		pending_results.push_back(o);
	endtask

	// result side
	always @(posedge clk) begin
		outcome_t e;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result mex %0d status %0d", $time,
					m_tdata[VB:0], m_tdata[VB+2:VB+1]);
				errors++;
			end else begin
				e = pending_results.pop_front();
				if (m_tdata[VB:0] !== e.mex) begin
					$display("%0t: mex expected %0d got %0d (func %0d operand %h)", $time,
						e.mex, m_tdata[VB:0], e.fn, e.opnd);
					errors++;
				end
				if (m_tdata[VB+2:VB+1] !== e.st) begin
					$display("%0t: status expected %0d got %0d (func %0d operand %h)", $time,
						e.st, m_tdata[VB+2:VB+1], e.fn, e.opnd);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no request or result moved for %0d cycles", $time, idle_cycles);
			$display("[xor_mex_multiset_trie_core] ERROR");
			$finish;
		end
	end

	initial begin
		m_tready = 1'b0;
		rx_gap = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
				n_holds++;
			end else if (rx_gap > 0) begin
				m_tready <= 1'b0;
				rx_gap--;
			end else begin
				m_tready <= 1'b1;
				rx_gap = quiet ? 0 : pick_gap();
			end
		end
	end

	initial begin
		logic [VB-1:0] base;
		logic [VB-1:0] opnd;
		logic [VB-1:0] hole;
		logic [1:0]    fn;
		int            r;

		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = FN_INS;
		errors = 0;
		idle_cycles = 0;
		quiet = 1'b0;
		hold_req = 1'b0;
		max_mex = 0;
		base = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		dir_row(FN_QRY, 16'h0000, 1, 0, ST_OK);
		dir_row(FN_QRY, 16'hFFFF, 1, 0, ST_OK);
		dir_row(FN_REM, 16'h0000, 1, 0, ST_ABSENT);
		dir_row(FN_NONE, 16'hFFFF, 1, 0, ST_OK);
		dir_row(FN_INS, 16'h0000, 1, 0, ST_OK);
		dir_row(FN_QRY, 16'h0000, 1, 1, ST_OK);
		dir_row(FN_QRY, 16'h0001, 1, 0, ST_OK);
		dir_row(FN_INS, 16'h0000, 1, 0, ST_OK);
		dir_row(FN_REM, 16'h0000, 1, 0, ST_OK);
		dir_row(FN_INS, 16'hFFFF, 1, 0, ST_OK);
		dir_row(FN_QRY, 16'hFFFF, 0, 0, ST_OK);
		dir_row(FN_INS, 16'h0001, 1, 0, ST_OK);
		dir_row(FN_INS, 16'h0002, 1, 0, ST_OK);
		dir_row(FN_INS, 16'h0003, 1, 0, ST_OK);
		dir_row(FN_QRY, 16'h0000, 0, 0, ST_OK);
		dir_row(FN_QRY, 16'h0003, 0, 0, ST_OK);
		dir_row(FN_REM, 16'h0000, 1, 0, ST_OK);
		dir_row(FN_QRY, 16'h0000, 0, 0, ST_OK);
		dir_row(FN_REM, 16'h0000, 1, 0, ST_ABSENT);
		dir_row(FN_INS, 16'h8000, 1, 0, ST_OK);
		dir_row(FN_QRY, 16'h8000, 0, 0, ST_OK);
		dir_row(FN_NONE, 16'h1234, 1, 0, ST_OK);
		dir_row(FN_QRY, 16'h7FFF, 0, 0, ST_OK);
		foreach (dir_rows[i])
			issue_request(dir_rows[i].fn, dir_rows[i].opnd, dir_rows[i].typed,
				dir_rows[i].mex, dir_rows[i].st);

		// clustered values so that sub-tries fill up and queries walk deep
		for (int i = 0; i < RAND_ITEMS; i++) begin
			if (i % 150 == 0) begin
				case ((i / 150) % 3)
					0: base = '0;
					1: base = 16'hFFE0;
					default: base = VB'($urandom) & 16'hFFE0;
				endcase
			end
			if (i == 300)
				hold_req = 1'b1;
			quiet = (i >= 450 && i < 550);
			r = $urandom_range(0, 99);
			if (r < 45)
				fn = FN_INS;
			else if (r < 70)
				fn = FN_REM;
			else if (r < 96)
				fn = FN_QRY;
			else
				fn = FN_NONE;
			if ($urandom_range(0, 99) < 75)
				opnd = base | 16'($urandom_range(0, 31));
			else
				opnd = VB'($urandom);
			issue_request(fn, opnd, 0, 0, ST_OK);
		end

		// empty a few values completely, then query around them
		quiet = 1'b0;
		repeat (6) begin
			hole = VB'($urandom);
			while (mult_cnt[hole] != 0)
				issue_request(FN_REM, hole, 0, 0, ST_OK);
			issue_request(FN_REM, hole, 1, 0, ST_ABSENT);
			repeat (3) issue_request(FN_QRY, hole ^ 16'($urandom_range(0, 7)), 0, 0, ST_OK);
			issue_request(FN_QRY, VB'($urandom), 0, 0, ST_OK);
		end

		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (2 * (VB + 3)) @(posedge clk);

		$display("covered %0d requests: %0d queries (%0d on a full set, largest other mex %0d),",
			n_req, n_qry, n_full, max_mex);
		$display("%0d absent removals, %0d saturated inserts, %0d unused selectors, %0d long stalls",
			n_absent, n_sat, n_none, n_holds);
		if (errors == 0)
			$display("[xor_mex_multiset_trie_core] OK");
		else
			$display("[xor_mex_multiset_trie_core] ERROR");
		$finish;
	end

endmodule
